>>> hw/rtl/cgb_pkg.sv
// ----------------------------------------------------------------------------
// cgb_pkg
// Shared widths, register indices and types of the clipped glyph blitter.
// ----------------------------------------------------------------------------
package cgb_pkg;

  // field widths
  localparam int COORD_W      = 13;
  localparam int REG_W        = 13;
  localparam int INDEX_W      = 24;
  localparam int COLOR_W      = 32;
  localparam int GLYPH_BITS   = 64;
  localparam int GLYPH_STRIDE = 8;
  localparam int CFG_IDX_W    = 1;

  // register indices of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // register values after reset
  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [INDEX_W-1:0]        index_t;

  // status of the serial row base multiplier
  typedef struct packed {
    logic   done;
    index_t product;
  } mul_status_t;

endpackage

>>> hw/rtl/clipped_glyph_blitter_unit.sv
// ----------------------------------------------------------------------------
// clipped_glyph_blitter_unit
// Draws one bitmap glyph per command as a stream of clipped framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   A command (position, glyph bitmap, colour) is taken at a clock edge with
//   start high and busy low. busy stays high until the cycle that carries the
//   final write of the command.
//   Each write appears for one cycle with out_strobe high: linear index
//   (row * screen_width + column, low 24 bits), colour, and out_last_write
//   set on the final write of the command. A command with no visible pixel
//   gives no write at all.
//   Sequence: busy stays high equally long for every command, whatever
//   the glyph. The block first runs the bit-serial multiply of the start
//   row by the width and takes over its product, then one bitmap cell is
//   scanned per cycle, and the flush state releases the held-back final
//   write, which is on the write ports in the first cycle with busy low.
//   The next command is taken at the end of that cycle at the earliest.
//   Writes cannot be stalled; the receiver must take one per cycle.
//   Write screen width and height on the cfg port only while busy is low;
//   the block does not enforce this. Reset (rst_n low, synchronous) returns
//   to idle, drops any command in flight and sets the screen to 640 x 480.
// ----------------------------------------------------------------------------
module clipped_glyph_blitter_unit #(
  parameter int GLYPH_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cgb_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [cgb_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [cgb_pkg::GLYPH_BITS-1:0]      in_glyph_bits,
  input  logic [cgb_pkg::COLOR_W-1:0]         in_ink_color,
  // write channel
  output logic                                out_strobe,
  output logic [cgb_pkg::INDEX_W-1:0]         out_pixel_index,
  output logic [cgb_pkg::COLOR_W-1:0]         out_pixel_value,
  output logic                                out_last_write,
  // configuration
  input  logic                                cfg_we,
  input  logic [cgb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cgb_pkg::REG_W-1:0]           cfg_data
);

  localparam int CNT_W   = $clog2(GLYPH_DIM);
  localparam int POS_W   = cgb_pkg::COORD_W + 1;
  localparam int RowSkip = cgb_pkg::GLYPH_STRIDE - GLYPH_DIM + 1;
  localparam logic [CNT_W-1:0] DimLast = CNT_W'(GLYPH_DIM - 1);

  // state codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [cgb_pkg::REG_W-1:0]      width_r, height_r;
  logic signed [POS_W-1:0]        x0_r, x0_nxt;
  logic signed [POS_W-1:0]        px_r, px_nxt;
  logic signed [POS_W-1:0]        py_r, py_nxt;
  logic [CNT_W-1:0]               col_r, col_nxt;
  logic [CNT_W-1:0]               row_r, row_nxt;
  logic [cgb_pkg::GLYPH_BITS-1:0] glyph_r, glyph_nxt;
  logic [cgb_pkg::COLOR_W-1:0]    color_r, color_nxt;
  cgb_pkg::index_t                row_base_r, row_base_nxt;
  cgb_pkg::index_t                pend_idx_r, pend_idx_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic                           strobe_r, strobe_nxt;
  logic                           last_r, last_nxt;
  cgb_pkg::index_t                oidx_r, oidx_nxt;
  logic [cgb_pkg::COLOR_W-1:0]    oval_r, oval_nxt;

  logic                           accept;
  logic                           px_in, py_in, hit;
  cgb_pkg::index_t                cur_idx;
  cgb_pkg::mul_status_t           mul_status;

  assign accept = start && (state_r == ST_IDLE);

  // width times start row, one bit per cycle
  cgb_row_base_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .mcand  (width_r),
    .mplier (in_pos_y),
    .status (mul_status)
  );

  // clip test and index of the current cell
  assign px_in   = !px_r[POS_W-1] && (px_r[cgb_pkg::COORD_W-1:0] < width_r);
  assign py_in   = !py_r[POS_W-1] && (py_r[cgb_pkg::COORD_W-1:0] < height_r);
  assign hit     = glyph_r[0] && px_in && py_in;
  assign cur_idx = row_base_r
                 + cgb_pkg::index_t'(px_r[cgb_pkg::COORD_W-1:0]);

  // sequencer: one cell per cycle, last write held back by one hit
  always_comb begin
    state_nxt      = state_r;
    x0_nxt         = x0_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    glyph_nxt      = glyph_r;
    color_nxt      = color_r;
    row_base_nxt   = row_base_r;
    pend_idx_nxt   = pend_idx_r;
    pend_valid_nxt = pend_valid_r;
    strobe_nxt     = 1'b0;
    last_nxt       = 1'b0;
    oidx_nxt       = oidx_r;
    oval_nxt       = oval_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          x0_nxt         = POS_W'(in_pos_x);
          px_nxt         = POS_W'(in_pos_x);
          py_nxt         = POS_W'(in_pos_y);
          glyph_nxt      = in_glyph_bits;
          color_nxt      = in_ink_color;
          col_nxt        = '0;
          row_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_status.done) begin
          row_base_nxt = mul_status.product;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (pend_valid_r) begin
            strobe_nxt = 1'b1;
            oidx_nxt   = pend_idx_r;
            oval_nxt   = color_r;
          end
          pend_idx_nxt   = cur_idx;
          pend_valid_nxt = 1'b1;
        end
        if (col_r == DimLast) begin
          col_nxt      = '0;
          px_nxt       = x0_r;
          py_nxt       = py_r + POS_W'(1);
          row_base_nxt = row_base_r + cgb_pkg::index_t'(width_r);
          glyph_nxt    = glyph_r >> RowSkip;
          if (row_r == DimLast) begin
            state_nxt = ST_FLUSH;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt   = col_r + 1'b1;
          px_nxt    = px_r + POS_W'(1);
          glyph_nxt = glyph_r >> 1;
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r) begin
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
          oidx_nxt   = pend_idx_r;
          oval_nxt   = color_r;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
      width_r      <= cgb_pkg::WIDTH_RESET;
      height_r     <= cgb_pkg::HEIGHT_RESET;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      strobe_r     <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cgb_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_data;
          cgb_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    glyph_r    <= glyph_nxt;
    color_r    <= color_nxt;
    row_base_r <= row_base_nxt;
    pend_idx_r <= pend_idx_nxt;
    last_r     <= last_nxt;
    oidx_r     <= oidx_nxt;
    oval_r     <= oval_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_pixel_index = oidx_r;
  assign out_pixel_value = oval_r;
  assign out_last_write  = last_r;

endmodule

>>> hw/rtl/cgb_row_base_mul.sv
// ----------------------------------------------------------------------------
// cgb_row_base_mul
// Bit-serial shift-add multiplier: screen width times signed start row,
// modulo 2^24, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cgb_row_base_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [cgb_pkg::REG_W-1:0]        mcand,
  input  cgb_pkg::coord_t                  mplier,
  output cgb_pkg::mul_status_t             status
);

  localparam int CNT_W = $clog2(cgb_pkg::COORD_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(cgb_pkg::COORD_W - 1);

  cgb_pkg::index_t              acc_r, acc_nxt;
  cgb_pkg::index_t              mcand_r, mcand_nxt;
  logic [cgb_pkg::COORD_W-1:0]  mplier_r, mplier_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         run_r, run_nxt;
  logic                         done_r, done_nxt;
  cgb_pkg::index_t              addend;

  // one partial product per cycle, the sign bit carries negative weight
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    addend     = mplier_r[0] ? mcand_r : '0;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = cgb_pkg::index_t'(mcand);
      mplier_nxt = mplier;
      cnt_nxt    = '0;
      run_nxt    = 1'b1;
    end else if (run_r) begin
      if (cnt_r == LastStep) begin
        acc_nxt  = acc_r - addend;
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        acc_nxt = acc_r + addend;
      end
      mcand_nxt  = {mcand_r[cgb_pkg::INDEX_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[cgb_pkg::COORD_W-1:1]};
      cnt_nxt    = cnt_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign status.done    = done_r;
  assign status.product = acc_r;

endmodule

>>> bench/tb_clipped_glyph_blitter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_glyph_blitter_unit
// Draws glyphs at and around the screen edges under a range of screen sizes
// (zero, one, 4096, 8191 and in between) and checks every framebuffer write
// against a predicted list of clipped pixel writes, in order.
// ----------------------------------------------------------------------------
module tb_clipped_glyph_blitter_unit;

  localparam int GLYPH_DIM   = 8;
  localparam int CMD_CYCLES  = GLYPH_DIM * GLYPH_DIM + 15;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 50;
  localparam int N_SCREENS   = 10;

  typedef struct packed {
    cgb_pkg::index_t             pixel_index;
    logic [cgb_pkg::COLOR_W-1:0] pixel_value;
    logic                        last_write;
  } fb_write_t;

  // expected framebuffer writes for every accepted draw transaction
  class fb_write_checker;
    logic [cgb_pkg::REG_W-1:0] scr_width  = cgb_pkg::WIDTH_RESET;
    logic [cgb_pkg::REG_W-1:0] scr_height = cgb_pkg::HEIGHT_RESET;
    fb_write_t                 expected_writes[$];
    int                        n_fail = 0;

    function void set_reg(logic [cgb_pkg::CFG_IDX_W-1:0] idx,
                          logic [cgb_pkg::REG_W-1:0] data);
      if (idx == cgb_pkg::REG_SCREEN_WIDTH) begin
        scr_width = data;
      end else if (idx == cgb_pkg::REG_SCREEN_HEIGHT) begin
        scr_height = data;
      end
    endfunction

    // clip every set glyph cell against the screen, row by row
    function void add_command(cgb_pkg::coord_t pos_x, cgb_pkg::coord_t pos_y,
                              logic [cgb_pkg::GLYPH_BITS-1:0] glyph,
                              logic [cgb_pkg::COLOR_W-1:0] ink);
      int        px;
      int        py;
      logic [63:0] lin;
      fb_write_t prev;
      bit        have_prev;
      have_prev = 1'b0;
      for (int r = 0; r < GLYPH_DIM; r++) begin
        py = int'(pos_y) + r;
        if (py < 0 || py >= int'(scr_height)) continue;
        for (int c = 0; c < GLYPH_DIM; c++) begin
          px = int'(pos_x) + c;
          if (!glyph[r * cgb_pkg::GLYPH_STRIDE + c]) continue;
          if (px < 0 || px >= int'(scr_width)) continue;
          if (have_prev) expected_writes.push_back(prev);
          lin = 64'(scr_width) * 64'(py) + 64'(px);
          prev.pixel_index = lin[cgb_pkg::INDEX_W-1:0];
          prev.pixel_value = ink;
          prev.last_write  = 1'b0;
          have_prev = 1'b1;
        end
      end
      // final write of the command carries the last flag
      if (have_prev) begin
        prev.last_write = 1'b1;
        expected_writes.push_back(prev);
      end
    endfunction

    function void report(string msg);
      n_fail++;
      if (n_fail <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_write(cgb_pkg::index_t idx, logic [cgb_pkg::COLOR_W-1:0] value,
                              logic last);
      fb_write_t exp_w;
      if (expected_writes.size() == 0) begin
        report($sformatf("unexpected write index %0h value %h last %b", idx, value, last));
        return;
      end
      exp_w = expected_writes.pop_front();
      if (exp_w.pixel_index !== idx || exp_w.pixel_value !== value ||
          exp_w.last_write !== last) begin
        report($sformatf("expected index %0h value %h last %b, got %0h %h %b",
                         exp_w.pixel_index, exp_w.pixel_value, exp_w.last_write,
                         idx, value, last));
      end
    endfunction

    function int outstanding();
      return expected_writes.size();
    endfunction

    function void close_out();
      if (expected_writes.size() != 0)
        report($sformatf("%0d writes never arrived", expected_writes.size()));
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  cgb_pkg::coord_t                in_pos_x;
  cgb_pkg::coord_t                in_pos_y;
  logic [cgb_pkg::GLYPH_BITS-1:0] in_glyph_bits;
  logic [cgb_pkg::COLOR_W-1:0]    in_ink_color;
  logic                           out_strobe;
  cgb_pkg::index_t                out_pixel_index;
  logic [cgb_pkg::COLOR_W-1:0]    out_pixel_value;
  logic                           out_last_write;
  logic                           cfg_we;
  logic [cgb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cgb_pkg::REG_W-1:0]      cfg_data;

  fb_write_checker board = new();
  int              cycle_count = 0;

  clipped_glyph_blitter_unit #(
    .GLYPH_DIM (GLYPH_DIM)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_glyph_bits   (in_glyph_bits),
    .in_ink_color    (in_ink_color),
    .out_strobe      (out_strobe),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .out_last_write  (out_last_write),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_clipped_glyph_blitter_unit failed");
      $finish;
    end
  end

  // monitor: register writes, write strobes and accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.set_reg(cfg_index, cfg_data);
      if (out_strobe) board.check_write(out_pixel_index, out_pixel_value, out_last_write);
      if (start && !busy) board.add_command(in_pos_x, in_pos_y, in_glyph_bits, in_ink_color);
    end
  end

  // coordinate near the visible span, at its edges, or anywhere
  function automatic cgb_pkg::coord_t pick_coord(int extent);
    int e;
    int v;
    e = (extent > 4095) ? 4095 : extent;
    case ($urandom_range(0, 9)) inside
      [0:5]: v = int'($urandom_range(0, e + 8)) - 8;
      [6:7]: begin
        if ($urandom_range(0, 1) == 0) v = int'($urandom_range(0, 8)) - 8;
        else v = e - int'($urandom_range(0, 8));
      end
      default: v = int'($urandom_range(0, 8191)) - 4096;
    endcase
    if (v > 4095) v = 4095;
    return cgb_pkg::coord_t'(v);
  endfunction

  function automatic logic [cgb_pkg::GLYPH_BITS-1:0] pick_glyph();
    case ($urandom_range(0, 7))
      4: return {$urandom, $urandom} & {$urandom, $urandom};
      5: return {$urandom, $urandom} | {$urandom, $urandom};
      6: return 64'd1 << $urandom_range(0, 63);
      7: return ($urandom_range(0, 1) == 0) ? '1 : '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one draw transaction; optionally hold off until the block is idle first
  task automatic run_cmd(input cgb_pkg::coord_t x, input cgb_pkg::coord_t y,
                         input logic [cgb_pkg::GLYPH_BITS-1:0] g,
                         input logic [cgb_pkg::COLOR_W-1:0] ink, input int gap,
                         input bit settle);
    if (gap > 0) begin
      start <= 1'b0;
      if (settle) while (busy) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_pos_x      <= x;
    in_pos_y      <= y;
    in_glyph_bits <= g;
    in_ink_color  <= ink;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    while (busy || board.outstanding() != 0) @(negedge clk);
    repeat (CMD_CYCLES) @(negedge clk);
  endtask

  task automatic set_screen(input logic [cgb_pkg::REG_W-1:0] w,
                            input logic [cgb_pkg::REG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= cgb_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= cgb_pkg::REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int pick_gap();
    return $urandom_range(0, 11);
  endfunction

  initial begin
    int  scr_w[N_SCREENS];
    int  scr_h[N_SCREENS];
    bit  quiet;
    int  gap;
    cgb_pkg::coord_t cx;
    cgb_pkg::coord_t cy;
    logic [cgb_pkg::GLYPH_BITS-1:0] gl;

    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_glyph_bits = '0;
    in_ink_color  = '0;
    cfg_we        = 1'b0;
    cfg_index     = cgb_pkg::REG_SCREEN_WIDTH;
    cfg_data      = '0;

    // screen sizes: reset size first, then extremes and odd sizes
    scr_w = '{640, 1, 8191, 0, 640, 4096, 8191, 1, 4097, 0};
    scr_h = '{480, 1, 8191, 480, 0, 4096, 1, 8191, 3000, 0};
    scr_w[9] = $urandom_range(1, 40);
    scr_h[9] = $urandom_range(1, 40);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed commands on the reset screen of 640 x 480
    run_cmd(13'sd0, 13'sd0, '1, 32'hFFFF_FFFF, pick_gap(), 1'b0);
    run_cmd(13'sd0, 13'sd0, '0, 32'h1234_5678, pick_gap(), 1'b1);
    run_cmd(-13'sd4096, -13'sd4096, '1, 32'h0, pick_gap(), 1'b0);
    run_cmd(13'sd4095, 13'sd4095, '1, 32'hFFFF_FFFF, pick_gap(), 1'b1);
    run_cmd(-13'sd7, -13'sd7, '1, 32'hA5A5_5A5A, pick_gap(), 1'b0);
    run_cmd(13'sd639, 13'sd479, '1, 32'h0, pick_gap(), 1'b0);
    run_cmd(13'sd636, 13'sd476, '1, 32'h8000_0001, pick_gap(), 1'b1);
    run_cmd(13'sd632, 13'sd472, '1, 32'h7FFF_FFFE, 0, 1'b0);
    run_cmd(-13'sd3, 13'sd100, 64'hAAAA_AAAA_AAAA_AAAA, 32'hDEAD_BEEF, 0, 1'b0);
    run_cmd(13'sd100, -13'sd3, 64'h5555_5555_5555_5555, 32'h0F0F_F0F0, pick_gap(), 1'b0);
    run_cmd(13'sd0, 13'sd0, 64'h1, 32'hFFFF_FFFF, pick_gap(), 1'b1);
    run_cmd(13'sd0, 13'sd0, 64'h8000_0000_0000_0000, 32'h0, pick_gap(), 1'b0);
    run_cmd(-13'sd8, 13'sd0, '1, 32'h1, pick_gap(), 1'b0);
    run_cmd(13'sd640, 13'sd0, '1, 32'h2, pick_gap(), 1'b1);
    run_cmd(13'sd0, 13'sd480, '1, 32'h3, pick_gap(), 1'b0);
    run_cmd(-13'sd1, -13'sd1, '1, 32'h4, 0, 1'b0);
    run_cmd(13'sd200, 13'sd200, 64'h0123_4567_89AB_CDEF, 32'h8000_0001, pick_gap(), 1'b0);
    run_cmd(-13'sd4096, 13'sd0, '1, 32'h5, pick_gap(), 1'b0);
    run_cmd(13'sd0, 13'sd4095, '1, 32'h6, pick_gap(), 1'b1);
    run_cmd(13'sd320, 13'sd240, 64'h8100_0000_0000_0081, 32'hCAFE_F00D, pick_gap(), 1'b0);

    // random commands under each screen size
    for (int s = 0; s < N_SCREENS; s++) begin
      if (s != 0) begin
        start <= 1'b0;
        drain();
        set_screen(cgb_pkg::REG_W'(scr_w[s]), cgb_pkg::REG_W'(scr_h[s]));
        if (s == 2) begin
          // index overflow near the bottom right of the largest screen
          run_cmd(13'sd4088, 13'sd4088, '1, 32'h0BAD_0BAD, pick_gap(), 1'b0);
          run_cmd(13'sd4095, 13'sd4095, '1, 32'h1, pick_gap(), 1'b1);
        end
      end
      quiet = 1'b0;
      for (int k = 0; k < RAND_ITEMS; k++) begin
        // bursts without any idling now and then
        if (k % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
        gap = quiet ? 0 : pick_gap();
        cx  = pick_coord(scr_w[s]);
        cy  = pick_coord(scr_h[s]);
        gl  = pick_glyph();
        run_cmd(cx, cy, gl, $urandom, gap, bit'($urandom_range(0, 1)));
      end
    end

    start <= 1'b0;
    drain();
    board.close_out();
    if (board.n_fail == 0) begin
      $display("tb_clipped_glyph_blitter_unit passed");
    end else begin
      $display("tb_clipped_glyph_blitter_unit failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cgb_pkg.sv
hw/rtl/cgb_row_base_mul.sv
hw/rtl/clipped_glyph_blitter_unit.sv
bench/tb_clipped_glyph_blitter_unit.sv
